@@ src/btfw_pkg.sv @@
// Shared constants, codes and types of the BMP threshold frame buffer writer.
package btfw_pkg;

  localparam int SCREEN_WIDTH  = 84;
  localparam int SCREEN_HEIGHT = 48;
  localparam int STORE_SIZE    = (SCREEN_WIDTH * SCREEN_HEIGHT) / 8;
  localparam int ADDR_W        = $clog2(STORE_SIZE);
  localparam int IDX_W         = $clog2(8 * SCREEN_WIDTH + 128);

  localparam logic [15:0] OFF_DATA_START = 16'd10;
  localparam logic [15:0] OFF_HEIGHT     = 16'd18;
  localparam logic [15:0] OFF_WIDTH      = 16'd22;
  localparam logic [15:0] OFFSET_MAX     = 16'hFFFF;
  localparam logic [7:0]  MIN_DATA_START = 8'd23;
  localparam logic [3:0]  THR_MAX        = 4'd14;

  localparam logic [1:0] REG_ORIGIN_COLUMN = 2'd0;
  localparam logic [1:0] REG_ORIGIN_ROW    = 2'd1;
  localparam logic [1:0] REG_THRESHOLD     = 2'd2;

  typedef enum logic [1:0] {
    MODE_FILE,
    MODE_READ,
    MODE_CLEAR,
    MODE_NONE
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE,
    ST_REJECT,
    ST_DRAWN,
    ST_SKIP
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SEEK,
    PH_PIXELS,
    PH_IDLE
  } phase_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_PIX_RD0,
    S_PIX_WR0,
    S_PIX_WR1,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] byte_value;
    logic       start_of_file;
    logic [8:0] read_address;
  } request_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic latch;
    logic decode;
    logic rd_pix0;
    logic wr_pix0;
    logic wr_pix1;
    logic finish;
    logic clear_step;
  } ctrl_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  draw;
    logic  clear_last;
  } dp_status_t;

endpackage

@@ src/bmp_threshold_framebuffer_writer.sv @@
// Top level: BMP byte stream to thresholded page-organized frame store.
// Sequence: an accepted beat goes through decode, then for a drawn pixel byte through a pixel
// read and two pixel writes (two read-modify-writes over the frame store's single write port),
// then finish, from which done is registered; a clear then sweeps all 504 store bytes.
// Reset: a sweep zeroes all 504 frame store bytes with busy high; config takes writes meanwhile.
// No beat is taken while busy; done is a one-cycle strobe; the receiver cannot stall.
module bmp_threshold_framebuffer_writer (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  btfw_pkg::request_t request,
  output logic               done,
  output btfw_pkg::result_t  result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data
);

  btfw_pkg::ctrl_cmd_t  cmd;
  btfw_pkg::dp_status_t stat;

  assign cfg_ready = 1'b1;

  btfw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  btfw_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (request),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted beat");

  a_accept_no_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result strobe right after accepted beat");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without work in progress");

endmodule

@@ src/btfw_ctrl.sv @@
// Controller state machine of the BMP threshold frame buffer writer.
module btfw_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  btfw_pkg::dp_status_t  stat,
  output btfw_pkg::ctrl_cmd_t   cmd,
  output logic                  busy,
  output logic                  done
);

  btfw_pkg::state_t state;
  btfw_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btfw_pkg::S_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == btfw_pkg::S_FINISH);
    end
  end

  always_comb begin
    cmd        = '0;
    busy       = 1'b1;
    state_next = state;
    unique case (state)
      btfw_pkg::S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = btfw_pkg::S_IDLE;
        end
      end
      btfw_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = btfw_pkg::S_DECODE;
        end
      end
      btfw_pkg::S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = stat.draw ? btfw_pkg::S_PIX_RD0 : btfw_pkg::S_FINISH;
      end
      btfw_pkg::S_PIX_RD0: begin
        cmd.rd_pix0 = 1'b1;
        state_next  = btfw_pkg::S_PIX_WR0;
      end
      btfw_pkg::S_PIX_WR0: begin
        cmd.wr_pix0 = 1'b1;
        state_next  = btfw_pkg::S_PIX_WR1;
      end
      btfw_pkg::S_PIX_WR1: begin
        cmd.wr_pix1 = 1'b1;
        state_next  = btfw_pkg::S_FINISH;
      end
      btfw_pkg::S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = (stat.mode == btfw_pkg::MODE_CLEAR) ? btfw_pkg::S_CLEAR
                                                         : btfw_pkg::S_IDLE;
      end
      default: begin
        state_next = btfw_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ src/btfw_datapath.sv @@
// Datapath: header parsing, draw counters, configuration and frame store.
module btfw_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [1:0]            cfg_index,
  input  logic [6:0]            cfg_data,
  input  btfw_pkg::request_t    request,
  input  btfw_pkg::ctrl_cmd_t   cmd,
  output btfw_pkg::dp_status_t  stat,
  output btfw_pkg::result_t     result
);

  localparam logic [btfw_pkg::IDX_W-1:0]  SW_IDX     = btfw_pkg::IDX_W'(btfw_pkg::SCREEN_WIDTH);
  localparam logic [btfw_pkg::IDX_W-1:0]  STORE_IDX  = btfw_pkg::IDX_W'(btfw_pkg::STORE_SIZE);
  localparam logic [btfw_pkg::ADDR_W-1:0] LAST_ADDR  =
    btfw_pkg::ADDR_W'(btfw_pkg::STORE_SIZE - 1);
  localparam logic [7:0]                  SW_COL     = 8'(btfw_pkg::SCREEN_WIDTH);
  localparam logic [8:0]                  SW_SUM     = 9'(btfw_pkg::SCREEN_WIDTH);
  localparam logic [6:0]                  SH_ROW     = 7'(btfw_pkg::SCREEN_HEIGHT);
  localparam logic [9:0]                  STORE_RD   = 10'(btfw_pkg::STORE_SIZE);

  logic [6:0] origin_column;
  logic [5:0] origin_row;
  logic [3:0] threshold_level;

  btfw_pkg::request_t req;

  logic [15:0]      file_offset;
  logic [7:0]       data_start;
  logic [7:0]       image_height;
  logic [7:0]       image_width;
  btfw_pkg::phase_t phase;
  logic [6:0]       row_byte_count;
  logic [7:0]       rows_left;
  logic [1:0]       pad_left;
  logic [2:0]       current_page;
  logic [2:0]       bit_in_page;
  logic [6:0]       current_column;

  logic [15:0]      file_offset_next;
  logic [7:0]       data_start_next;
  logic [7:0]       image_height_next;
  logic [7:0]       image_width_next;
  btfw_pkg::phase_t phase_next;
  logic [6:0]       row_byte_count_next;
  logic [7:0]       rows_left_next;
  logic [1:0]       pad_left_next;
  logic [2:0]       current_page_next;
  logic [2:0]       bit_in_page_next;
  logic [6:0]       current_column_next;

  btfw_pkg::status_t st;
  btfw_pkg::status_t pend_status;
  logic              do_draw;

  logic [btfw_pkg::IDX_W-1:0] pix_idx;
  logic [btfw_pkg::IDX_W-1:0] pix_idx1;
  logic                       pix_ok0;
  logic                       pix_ok1;
  logic                       pix_on0;
  logic                       pix_on1;
  logic [7:0]                 pix_mask;

  logic [btfw_pkg::IDX_W-1:0] cur_idx;
  logic [btfw_pkg::IDX_W-1:0] cur_idx1;
  logic [7:0]                 col1;
  logic [3:0]                 thr;

  logic [7:0]                  store [btfw_pkg::STORE_SIZE];
  logic [7:0]                  rdata;
  logic [btfw_pkg::ADDR_W-1:0] clr_addr;
  logic                        rd_en;
  logic [btfw_pkg::ADDR_W-1:0] rd_addr;
  logic                        wr_en;
  logic [btfw_pkg::ADDR_W-1:0] wr_addr;
  logic [7:0]                  wr_data;

  btfw_pkg::mode_t mode;
  logic            addr_ok;

  logic [15:0] off;
  logic [7:0]  ds;
  logic [7:0]  ht;
  logic [7:0]  wd;
  logic        bad;
  logic [6:0]  row_bytes;
  logic [6:0]  rbc_inc;
  logic [1:0]  pad_dec;
  logic [7:0]  rows_dec;
  logic [7:0]  b;

  assign mode    = btfw_pkg::mode_t'(req.mode);
  assign b       = req.byte_value;
  assign addr_ok = {1'b0, req.read_address} < STORE_RD;
  assign thr     = (threshold_level > btfw_pkg::THR_MAX) ? btfw_pkg::THR_MAX : threshold_level;

  assign cur_idx  = btfw_pkg::IDX_W'(current_page) * SW_IDX +
                    btfw_pkg::IDX_W'(current_column);
  assign cur_idx1 = cur_idx + btfw_pkg::IDX_W'(1);
  assign col1     = {1'b0, current_column} + 8'd1;
  assign pix_idx1 = pix_idx + btfw_pkg::IDX_W'(1);

  assign off = req.start_of_file ? 16'd0 : file_offset;
  assign ds  = req.start_of_file ? 8'd0 : data_start;
  assign ht  = req.start_of_file ? 8'd0 : image_height;
  assign wd  = req.start_of_file ? 8'd0 : image_width;

  assign bad = (ht == 8'd0) || b[0] ||
               ({2'b00, origin_column} + {1'b0, b} > SW_SUM) ||
               ({2'b00, origin_row} < (ht - 8'd1)) ||
               ({1'b0, origin_row} >= SH_ROW) ||
               (ds < btfw_pkg::MIN_DATA_START);

  assign row_bytes = wd[7:1];
  assign rbc_inc   = row_byte_count + 7'd1;
  assign pad_dec   = pad_left - 2'd1;
  assign rows_dec  = rows_left - 8'd1;

  always_comb begin
    logic enter_draw;
    enter_draw          = 1'b0;
    do_draw             = 1'b0;
    st                  = btfw_pkg::ST_SKIP;
    file_offset_next    = (off != btfw_pkg::OFFSET_MAX) ? off + 16'd1 : off;
    data_start_next     = ds;
    image_height_next   = ht;
    image_width_next    = wd;
    phase_next          = req.start_of_file ? btfw_pkg::PH_HEADER : phase;
    row_byte_count_next = row_byte_count;
    rows_left_next      = rows_left;
    pad_left_next       = pad_left;
    current_page_next   = current_page;
    bit_in_page_next    = bit_in_page;
    current_column_next = current_column;
    unique case (phase_next)
      btfw_pkg::PH_HEADER: begin
        if (off == btfw_pkg::OFF_DATA_START) begin
          data_start_next = b;
        end else if (off == btfw_pkg::OFF_HEIGHT) begin
          image_height_next = b;
        end else if (off == btfw_pkg::OFF_WIDTH) begin
          image_width_next = b;
          if (bad) begin
            phase_next = btfw_pkg::PH_IDLE;
            st         = btfw_pkg::ST_REJECT;
          end else begin
            current_page_next   = origin_row[5:3];
            bit_in_page_next    = origin_row[2:0];
            current_column_next = origin_column;
            rows_left_next      = ht;
            row_byte_count_next = 7'd0;
            pad_left_next       = 2'd0;
            phase_next          = (b == 8'd0) ? btfw_pkg::PH_IDLE : btfw_pkg::PH_SEEK;
            st                  = btfw_pkg::ST_DONE;
          end
        end
      end
      btfw_pkg::PH_SEEK: begin
        enter_draw = (off == {8'd0, ds});
      end
      btfw_pkg::PH_PIXELS: begin
        enter_draw = 1'b1;
      end
      btfw_pkg::PH_IDLE: begin
      end
    endcase
    if (enter_draw) begin
      phase_next = btfw_pkg::PH_PIXELS;
      if (pad_left != 2'd0) begin
        pad_left_next = pad_dec;
        if (pad_dec == 2'd0 && rows_left == 8'd0) begin
          phase_next = btfw_pkg::PH_IDLE;
        end
        st = btfw_pkg::ST_SKIP;
      end else begin
        do_draw             = 1'b1;
        st                  = btfw_pkg::ST_DRAWN;
        current_column_next = current_column + 7'd2;
        row_byte_count_next = rbc_inc;
        if (rbc_inc >= row_bytes) begin
          rows_left_next      = rows_dec;
          row_byte_count_next = 7'd0;
          if (rows_dec == 8'd0) begin
            phase_next = btfw_pkg::PH_IDLE;
          end else begin
            if (bit_in_page != 3'd0) begin
              bit_in_page_next = bit_in_page - 3'd1;
            end else begin
              bit_in_page_next  = 3'd7;
              current_page_next = current_page - 3'd1;
            end
            current_column_next = origin_column;
            pad_left_next       = 2'd0 - row_bytes[1:0];
          end
        end
      end
    end
  end

  assign stat.mode       = mode;
  assign stat.draw       = (mode == btfw_pkg::MODE_FILE) && do_draw;
  assign stat.clear_last = (clr_addr == LAST_ADDR);

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_column   <= 7'd0;
      origin_row      <= 6'd47;
      threshold_level <= 4'd7;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        btfw_pkg::REG_ORIGIN_COLUMN: origin_column   <= cfg_data;
        btfw_pkg::REG_ORIGIN_ROW:    origin_row      <= cfg_data[5:0];
        btfw_pkg::REG_THRESHOLD:     threshold_level <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req <= request;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      file_offset    <= 16'd0;
      data_start     <= 8'd0;
      image_height   <= 8'd0;
      image_width    <= 8'd0;
      phase          <= btfw_pkg::PH_HEADER;
      row_byte_count <= 7'd0;
      rows_left      <= 8'd0;
      pad_left       <= 2'd0;
      current_page   <= 3'd0;
      bit_in_page    <= 3'd0;
      current_column <= 7'd0;
    end else if (cmd.decode && mode == btfw_pkg::MODE_FILE) begin
      file_offset    <= file_offset_next;
      data_start     <= data_start_next;
      image_height   <= image_height_next;
      image_width    <= image_width_next;
      phase          <= phase_next;
      row_byte_count <= row_byte_count_next;
      rows_left      <= rows_left_next;
      pad_left       <= pad_left_next;
      current_page   <= current_page_next;
      bit_in_page    <= bit_in_page_next;
      current_column <= current_column_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      pend_status <= (mode == btfw_pkg::MODE_FILE) ? st : btfw_pkg::ST_DONE;
      pix_idx     <= cur_idx;
      pix_ok0     <= ({1'b0, current_column} < SW_COL) && (cur_idx < STORE_IDX);
      pix_ok1     <= (col1 < SW_COL) && (cur_idx1 < STORE_IDX);
      pix_on0     <= b[7:4] > thr;
      pix_on1     <= b[3:0] > thr;
      pix_mask    <= 8'd1 << bit_in_page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= stat.clear_last ? '0 : clr_addr + btfw_pkg::ADDR_W'(1);
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = req.read_address[btfw_pkg::ADDR_W-1:0];
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = 8'd0;
    if (cmd.decode) begin
      rd_en = (mode == btfw_pkg::MODE_READ) && addr_ok;
    end else if (cmd.rd_pix0) begin
      rd_en   = pix_ok0;
      rd_addr = pix_idx[btfw_pkg::ADDR_W-1:0];
    end else if (cmd.wr_pix0) begin
      rd_en   = pix_ok1;
      rd_addr = pix_idx1[btfw_pkg::ADDR_W-1:0];
      wr_en   = pix_ok0;
      wr_addr = pix_idx[btfw_pkg::ADDR_W-1:0];
      wr_data = pix_on0 ? (rdata | pix_mask) : (rdata & ~pix_mask);
    end else if (cmd.wr_pix1) begin
      wr_en   = pix_ok1;
      wr_addr = pix_idx1[btfw_pkg::ADDR_W-1:0];
      wr_data = pix_on1 ? (rdata | pix_mask) : (rdata & ~pix_mask);
    end else if (cmd.clear_step) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.read_data <= (mode == btfw_pkg::MODE_READ && addr_ok) ? rdata : 8'd0;
      result.status    <= pend_status;
    end
  end

endmodule

@@ tb/btfw_checker.sv @@
// Checker: predicts each result of the BMP threshold frame buffer writer and compares it.
module btfw_checker
  import btfw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  request_t   request,
  input  logic       done,
  input  result_t    result,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data,
  output int         errors,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0] page_mem [STORE_SIZE];
  logic [6:0] cfg_col;
  logic [5:0] cfg_row;
  logic [3:0] cfg_thr;

  logic [15:0] file_pos;
  logic [7:0]  data_start;
  logic [7:0]  img_h;
  logic [7:0]  img_w;
  phase_t      phase;
  logic [6:0]  row_done;
  logic [7:0]  rows_left;
  logic [1:0]  pad_left;
  logic [2:0]  page;
  logic [2:0]  bit_pos;
  logic [6:0]  col;

  result_t reply_q [$];

  function automatic void reset_model();
    foreach (page_mem[i]) page_mem[i] = '0;
    cfg_col    = '0;
    cfg_row    = 6'd47;
    cfg_thr    = 4'd7;
    file_pos   = '0;
    data_start = '0;
    img_h      = '0;
    img_w      = '0;
    phase      = PH_HEADER;
    row_done   = '0;
    rows_left  = '0;
    pad_left   = '0;
    page       = '0;
    bit_pos    = '0;
    col        = '0;
  endfunction

  function automatic void plot(int column, logic [3:0] nib, logic [3:0] thr);
    int idx;
    logic [7:0] mask;
    idx  = int'(page) * SCREEN_WIDTH + column;
    mask = 8'h01 << bit_pos;
    if (column >= SCREEN_WIDTH || idx >= STORE_SIZE) return;
    if (nib > thr) page_mem[idx] = page_mem[idx] | mask;
    else page_mem[idx] = page_mem[idx] & ~mask;
  endfunction

  function automatic status_t accept_header();
    if (img_h == 0 || img_w[0] || int'(cfg_col) + int'(img_w) > SCREEN_WIDTH ||
        int'(cfg_row) < int'(img_h) - 1 || int'(cfg_row) >= SCREEN_HEIGHT ||
        data_start < MIN_DATA_START) begin
      phase = PH_IDLE;
      return ST_REJECT;
    end
    page      = cfg_row[5:3];
    bit_pos   = cfg_row[2:0];
    col       = cfg_col;
    rows_left = img_h;
    row_done  = '0;
    pad_left  = '0;
    phase     = (img_w == 0) ? PH_IDLE : PH_SEEK;
    return ST_DONE;
  endfunction

  function automatic status_t paint_byte(logic [7:0] b);
    logic [3:0] thr;
    logic [6:0] row_bytes;
    thr       = (cfg_thr > THR_MAX) ? THR_MAX : cfg_thr;
    row_bytes = img_w[7:1];
    if (pad_left != 0) begin
      pad_left = pad_left - 2'd1;
      if (pad_left == 0 && rows_left == 0) phase = PH_IDLE;
      return ST_SKIP;
    end
    plot(int'(col), b[7:4], thr);
    plot(int'(col) + 1, b[3:0], thr);
    col      = col + 7'd2;
    row_done = row_done + 7'd1;
    if (row_done >= row_bytes) begin
      rows_left = rows_left - 8'd1;
      row_done  = '0;
      if (rows_left == 0) begin
        phase = PH_IDLE;
      end else begin
        if (bit_pos > 0) begin
          bit_pos = bit_pos - 3'd1;
        end else begin
          bit_pos = 3'd7;
          page    = page - 3'd1;
        end
        col      = cfg_col;
        pad_left = 2'd0 - row_bytes[1:0];
      end
    end
    return ST_DRAWN;
  endfunction

  function automatic status_t take_file_byte(logic [7:0] b, logic sof);
    status_t st;
    logic [15:0] off;
    st = ST_SKIP;
    if (sof) begin
      file_pos   = '0;
      phase      = PH_HEADER;
      data_start = '0;
      img_h      = '0;
      img_w      = '0;
    end
    off = file_pos;
    case (phase)
      PH_HEADER: begin
        if (off == OFF_DATA_START) data_start = b;
        else if (off == OFF_HEIGHT) img_h = b;
        else if (off == OFF_WIDTH) begin
          img_w = b;
          st    = accept_header();
        end
      end
      PH_SEEK: begin
        if (off == {8'd0, data_start}) begin
          phase = PH_PIXELS;
          st    = paint_byte(b);
        end
      end
      PH_PIXELS: st = paint_byte(b);
      default: ;
    endcase
    if (file_pos != OFFSET_MAX) file_pos = file_pos + 16'd1;
    return st;
  endfunction

  function automatic result_t fb_step(request_t r);
    result_t res;
    res        = '0;
    res.status = ST_DONE;
    case (mode_t'(r.mode))
      MODE_FILE: res.status = take_file_byte(r.byte_value, r.start_of_file);
      MODE_READ: begin
        if (r.read_address < STORE_SIZE) res.read_data = page_mem[r.read_address];
      end
      MODE_CLEAR: foreach (page_mem[i]) page_mem[i] = '0;
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    int bad;
    bad = 0;
    if (rst) begin
      reset_model();
      reply_q.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ORIGIN_COLUMN: cfg_col = cfg_data;
          REG_ORIGIN_ROW:    cfg_row = cfg_data[5:0];
          REG_THRESHOLD:     cfg_thr = cfg_data[3:0];
          default: ;
        endcase
      end
      if (done) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected result, read_data %02h status %0d",
                   $time, result.read_data, result.status);
          bad++;
        end else begin
          want = reply_q.pop_front();
          if (result.read_data !== want.read_data) begin
            $display("%0t: read_data mismatch, expected %02h, actual %02h",
                     $time, want.read_data, result.read_data);
            bad++;
          end
          if (result.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, result.status);
            bad++;
          end
        end
      end
      if (start && !busy) reply_q.push_back(fb_step(request));
      errors  <= errors + bad;
      pending <= reply_q.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
// Testbench top: drives BMP byte streams, store reads and clears into the frame buffer writer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import btfw_pkg::*;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  request_t   request;
  logic       done;
  result_t    result;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [6:0] cfg_data;
  int         errors;
  int         pending;

  logic [6:0] org_col;
  logic [5:0] org_row;
  bit         no_gaps;
  int         beats_sent;

  bmp_threshold_framebuffer_writer u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  btfw_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  function automatic request_t make_req(mode_t m, logic [7:0] b, logic s, logic [8:0] a);
    request_t r;
    r.mode          = m;
    r.byte_value    = b;
    r.start_of_file = s;
    r.read_address  = a;
    return r;
  endfunction

  function automatic int pick_edge(int hi);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return hi;
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  task automatic send_beat(input request_t r);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (r.mode != MODE_NONE) beats_sent++;
  endtask

  task automatic quiesce();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic program_regs(input logic [6:0] c, input logic [5:0] rw, input logic [3:0] t);
    logic [1:0] regs [3];
    logic [6:0] vals [3];
    regs    = '{REG_ORIGIN_COLUMN, REG_ORIGIN_ROW, REG_THRESHOLD};
    vals    = '{c, {1'b0, rw}, {3'b000, t}};
    org_col = c;
    org_row = rw;
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // mix reads, clears, idle modes and live register changes into the stream
  task automatic put_file_byte(input logic [7:0] b, input logic s);
    int roll;
    roll = $urandom_range(0, 199);
    if (roll < 16) begin
      send_beat(make_req(MODE_READ, 8'($urandom), 1'($urandom), 9'($urandom)));
    end else if (roll < 19) begin
      send_beat(make_req(MODE_NONE, 8'($urandom), 1'($urandom), 9'($urandom)));
    end else if (roll < 20) begin
      send_beat(make_req(MODE_CLEAR, 8'($urandom), 1'($urandom), 9'($urandom)));
    end else if (roll < 22) begin
      quiesce();
      program_regs(7'(pick_edge(83)), org_row, 4'(pick_edge(15)));
    end
    send_beat(make_req(MODE_FILE, b, s, 9'($urandom)));
  endtask

  task automatic send_file();
    int kind, maxw, w, h, ds, rb, pad, hdr_len, body, total, cut, row, addr;
    logic fits;
    logic [7:0] b;
    kind = $urandom_range(0, 15);
    maxw = SCREEN_WIDTH - int'(org_col);
    w    = 2 * $urandom_range(0, (maxw / 2 < 6) ? maxw / 2 : 6);
    h    = $urandom_range(1, (org_row < 5) ? int'(org_row) + 1 : 5);
    ds   = 23 + $urandom_range(0, 5);
    case (kind)
      1: h = 0;
      2: w = 2 * $urandom_range(0, 40) + 1;
      3: w = $urandom_range(maxw + 1, 255);
      4: h = $urandom_range(int'(org_row) + 2, 255);
      5: ds = $urandom_range(0, 22);
      6: w = 0;
      9: begin
        w = 2 * (maxw / 2);
        h = (h > 2) ? 2 : h;
      end
      10: begin
        w = (maxw >= 2) ? 2 : 0;
        h = int'(org_row) + 1;
      end
      default: ;
    endcase
    fits    = (kind < 1 || kind > 5);
    rb      = w / 2;
    pad     = (4 - rb % 4) % 4;
    hdr_len = (ds > 23) ? ds : 23;
    body    = fits ? h * (rb + pad) + $urandom_range(0, 3) : $urandom_range(0, 6);
    total   = hdr_len + body;
    cut     = (kind == 7) ? $urandom_range(1, total - 1) : total;
    for (int i = 0; i < cut; i++) begin
      if (i == int'(OFF_DATA_START)) b = 8'(ds);
      else if (i == int'(OFF_HEIGHT)) b = 8'(h);
      else if (i == int'(OFF_WIDTH)) b = 8'(w);
      else b = 8'($urandom);
      put_file_byte(b, (i == 0) && (kind != 8));
    end
    for (int k = 0; k < 6; k++) begin
      if (fits && w > 0) begin
        row  = int'(org_row) - $urandom_range(0, h - 1);
        addr = (row / 8) * SCREEN_WIDTH + int'(org_col) + $urandom_range(0, w - 1);
      end else begin
        addr = $urandom_range(0, 511);
      end
      send_beat(make_req(MODE_READ, 8'($urandom), 1'($urandom), 9'(addr)));
    end
  endtask

  initial begin
    int file_no;
    int first_random;
    rst        = 1'b1;
    start      = 1'b0;
    request    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_ORIGIN_COLUMN;
    cfg_data   = '0;
    org_col    = '0;
    org_row    = 6'd47;
    no_gaps    = 1'b0;
    beats_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_beat(make_req(MODE_NONE, 8'hFF, 1'b1, 9'h1FF));
    send_beat(make_req(MODE_READ, 8'h00, 1'b0, 9'd0));
    send_beat(make_req(MODE_READ, 8'hFF, 1'b1, 9'd503));
    send_beat(make_req(MODE_READ, 8'h00, 1'b0, 9'd504));
    send_beat(make_req(MODE_READ, 8'hFF, 1'b1, 9'h1FF));
    send_beat(make_req(MODE_FILE, 8'hFF, 1'b0, 9'h000));
    send_beat(make_req(MODE_FILE, 8'h00, 1'b0, 9'h1FF));
    send_beat(make_req(MODE_FILE, 8'hA5, 1'b0, 9'h0AA));
    send_beat(make_req(MODE_CLEAR, 8'h5A, 1'b1, 9'h155));
    send_beat(make_req(MODE_READ, 8'h00, 1'b0, 9'd0));
    send_beat(make_req(MODE_NONE, 8'h00, 1'b0, 9'h000));

    file_no      = 0;
    first_random = beats_sent;
    while (beats_sent - first_random < 1250) begin
      if (file_no < 4) begin
        quiesce();
        case (file_no)
          0: program_regs(7'd0, 6'd47, 4'd15);
          1: program_regs(7'd83, 6'd0, 4'd0);
          2: program_regs(7'd0, 6'd0, 4'd14);
          default: program_regs(7'd20, 6'd31, 4'd1);
        endcase
      end else if ($urandom_range(0, 2) == 0) begin
        quiesce();
        program_regs(7'(pick_edge(83)), 6'(pick_edge(47)), 4'(pick_edge(15)));
      end
      if ($urandom_range(0, 3) == 0) no_gaps = ~no_gaps;
      send_file();
      file_no++;
    end

    quiesce();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/btfw_pkg.sv
src/btfw_ctrl.sv
src/btfw_datapath.sv
src/bmp_threshold_framebuffer_writer.sv
tb/btfw_checker.sv
tb/tb_top.sv
